### hw/rtl/tsh_pkg.sv
// ----------------------------------------------------------------------------
// TCP SYN header builder package
// Shared constants, the header record type and the checksum fold function.
// ----------------------------------------------------------------------------
package tsh_pkg;

  localparam int unsigned HdrWords   = 20;
  localparam int unsigned IdxWidth   = 5;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CfgIdxW-1:0] CfgTtl    = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgWindow = 1'd1;

  localparam logic [7:0]  TtlReset    = 8'd64;
  localparam logic [15:0] WindowReset = 16'd1024;

  localparam logic [15:0] IpVerIhlTos = 16'h4500;
  localparam logic [15:0] IpTotalLen  = 16'h0028;
  localparam logic [7:0]  ProtoTcp    = 8'h06;
  localparam logic [15:0] TcpLenBytes = 16'd20;
  localparam logic [15:0] TcpOffSyn   = 16'h5002;

  localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(HdrWords - 1);

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] ident;
    logic [7:0]  ttl;
    logic [15:0] window;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
  } hdr_t;

  function automatic logic [15:0] csum_fold(input logic [18:0] raw);
    logic [16:0] s;
    logic [15:0] f;
    s = {1'b0, raw[15:0]} + {14'd0, raw[18:16]};
    f = s[15:0] + {15'd0, s[16]};
    return ~f;
  endfunction

endpackage

### hw/rtl/tsh_front.sv
// ----------------------------------------------------------------------------
// TCP SYN header builder front end
// Accepts request beats and computes both checksums in a two-stage pipeline.
// ----------------------------------------------------------------------------
module tsh_front import tsh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] source_address_i,
  input  logic [31:0] dest_address_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [15:0] ident_i,
  input  logic [7:0]  ttl_i,
  input  logic [15:0] window_i,
  output logic        push_o,
  output hdr_t        rec_o,
  input  logic        full_i
);

  logic        s1_valid_q, s2_valid_q;
  hdr_t        s1_rec_q, s2_rec_q;
  logic [17:0] addr_sum_q, ip_fix_q, tcp_fix_q;
  logic [17:0] addr_sum_d, ip_fix_d, tcp_fix_d;
  logic        s1_adv, s2_adv;
  hdr_t        s1_rec_d, s2_rec_d;
  logic [18:0] ip_raw, tcp_raw;

  assign s2_adv     = !s2_valid_q || !full_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_ready_o = s1_adv;
  assign push_o     = s2_valid_q && !full_i;
  assign rec_o      = s2_rec_q;

  always_comb begin
    s1_rec_d          = '0;
    s1_rec_d.src      = source_address_i;
    s1_rec_d.dst      = dest_address_i;
    s1_rec_d.sport    = source_port_i;
    s1_rec_d.dport    = dest_port_i;
    s1_rec_d.ident    = ident_i;
    s1_rec_d.ttl      = ttl_i;
    s1_rec_d.window   = window_i;
    addr_sum_d = {2'd0, source_address_i[31:16]} + {2'd0, source_address_i[15:0]}
               + {2'd0, dest_address_i[31:16]} + {2'd0, dest_address_i[15:0]};
    ip_fix_d   = {2'd0, IpVerIhlTos} + {2'd0, IpTotalLen} + {2'd0, ident_i}
               + {2'd0, ttl_i, ProtoTcp};
    tcp_fix_d  = {2'd0, source_port_i} + {2'd0, dest_port_i} + {2'd0, TcpOffSyn}
               + {2'd0, window_i} + {10'd0, ProtoTcp} + {2'd0, TcpLenBytes};
  end

  assign ip_raw  = {1'b0, addr_sum_q} + {1'b0, ip_fix_q};
  assign tcp_raw = {1'b0, addr_sum_q} + {1'b0, tcp_fix_q};

  always_comb begin
    s2_rec_d          = s1_rec_q;
    s2_rec_d.ip_csum  = csum_fold(ip_raw);
    s2_rec_d.tcp_csum = csum_fold(tcp_raw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= in_valid_i;
      if (s2_adv) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_rec_q   <= s1_rec_d;
      addr_sum_q <= addr_sum_d;
      ip_fix_q   <= ip_fix_d;
      tcp_fix_q  <= tcp_fix_d;
    end
    if (s2_adv && s1_valid_q) begin
      s2_rec_q <= s2_rec_d;
    end
  end

endmodule

### hw/rtl/tsh_queue.sv
// ----------------------------------------------------------------------------
// TCP SYN header builder queue
// Small FIFO of finished header records between front end and back end.
// ----------------------------------------------------------------------------
module tsh_queue import tsh_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  hdr_t rec_i,
  output logic full_o,
  input  logic pop_i,
  output logic avail_o,
  output hdr_t rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hdr_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q, wptr_d, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign avail_o = (cnt_q != '0);
  assign rec_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    if (pop_i)  rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= rec_i;
  end

endmodule

### hw/rtl/tsh_back.sv
// ----------------------------------------------------------------------------
// TCP SYN header builder back end
// Serializes one header record into twenty registered 16-bit output beats.
// ----------------------------------------------------------------------------
module tsh_back import tsh_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                avail_i,
  input  hdr_t                rec_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         header_word_o,
  output logic [IdxWidth-1:0] word_index_o,
  output logic                last_word_o
);

  hdr_t                rec_q;
  logic                busy_q, busy_d;
  logic [IdxWidth-1:0] idx_q, idx_d;
  logic                oval_q, oval_d;
  logic [15:0]         word_q, word_d;
  logic [IdxWidth-1:0] oidx_q;
  logic                last_q;
  logic                load, at_last;

  assign load    = busy_q && (!oval_q || out_ready_i);
  assign at_last = (idx_q == LastIdx);
  assign pop_o   = avail_i && (!busy_q || (load && at_last));

  always_comb begin
    case (idx_q)
      5'd0:    word_d = IpVerIhlTos;
      5'd1:    word_d = IpTotalLen;
      5'd2:    word_d = rec_q.ident;
      5'd4:    word_d = {rec_q.ttl, ProtoTcp};
      5'd5:    word_d = rec_q.ip_csum;
      5'd6:    word_d = rec_q.src[31:16];
      5'd7:    word_d = rec_q.src[15:0];
      5'd8:    word_d = rec_q.dst[31:16];
      5'd9:    word_d = rec_q.dst[15:0];
      5'd10:   word_d = rec_q.sport;
      5'd11:   word_d = rec_q.dport;
      5'd16:   word_d = TcpOffSyn;
      5'd17:   word_d = rec_q.window;
      5'd18:   word_d = rec_q.tcp_csum;
      default: word_d = 16'h0000;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    oval_d = oval_q && !out_ready_i;
    if (load) begin
      oval_d = 1'b1;
      idx_d  = idx_q + 1'b1;
      if (at_last) busy_d = 1'b0;
    end
    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) rec_q <= rec_i;
    if (load) begin
      word_q <= word_d;
      oidx_q <= idx_q;
      last_q <= at_last;
    end
  end

  assign out_valid_o   = oval_q;
  assign header_word_o = word_q;
  assign word_index_o  = oidx_q;
  assign last_word_o   = last_q;

  a_last_marks_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oval_q |-> (last_q == (oidx_q == LastIdx)))
    else $error("last flag does not match word index");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= LastIdx))
    else $error("word counter out of range");

  a_next_word_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oval_q && out_ready_i && !last_q) |=>
      (oval_q && oidx_q == $past(oidx_q) + 1'b1))
    else $error("header words not emitted back to back in order");

endmodule

### hw/rtl/tcp_syn_header_builder.sv
// Throughput is set by the 16-bit output serializer.
// Requests are accepted back to back while the two-stage checksum pipeline and
// the record queue have room; output stalls fill the queue and then stall input.
// Reset clears all control state; TTL resets to 64 and window to 1024.
// ----------------------------------------------------------------------------
// TCP SYN header builder
// Builds IPv4 plus TCP SYN headers with both Internet checksums.
// ----------------------------------------------------------------------------
module tcp_syn_header_builder import tsh_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         source_address_i,
  input  logic [31:0]         dest_address_i,
  input  logic [15:0]         source_port_i,
  input  logic [15:0]         dest_port_i,
  input  logic [15:0]         ident_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         header_word_o,
  output logic [IdxWidth-1:0] word_index_o,
  output logic                last_word_o
);

  logic [7:0]  ttl_q;
  logic [15:0] window_q;
  logic        push, full, pop, avail;
  hdr_t        rec_in, rec_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q    <= TtlReset;
      window_q <= WindowReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgTtl:    ttl_q    <= cfg_wdata_i[7:0];
        CfgWindow: window_q <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  tsh_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .source_address_i,
    .dest_address_i,
    .source_port_i,
    .dest_port_i,
    .ident_i,
    .ttl_i    (ttl_q),
    .window_i (window_q),
    .push_o   (push),
    .rec_o    (rec_in),
    .full_i   (full)
  );

  tsh_queue #(.Depth(QDepth)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .rec_o   (rec_out)
  );

  tsh_back u_back (
    .clk_i,
    .rst_ni,
    .avail_i (avail),
    .rec_i   (rec_out),
    .pop_o   (pop),
    .out_valid_o,
    .out_ready_i,
    .header_word_o,
    .word_index_o,
    .last_word_o
  );

endmodule
